// ----- rtl/core/ccbu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccbu_pkg
// Shared constants for the centre crop and bilinear 2x upscale block:
// register map, reset sizes and field widths.
// ----------------------------------------------------------------------------
package ccbu_pkg;

  // Configuration register width and the smallest usable frame size
  localparam int CFG_W     = 12;
  localparam int MIN_SIZE  = 8;

  // Reset frame geometry
  localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd1920;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd1080;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // Payload widths
  localparam int PIX_W   = 8;
  localparam int QUAD_W  = 11;
  localparam int OUT_W   = 2 * QUAD_W + 4 * PIX_W;          // 54 bits of fields
  localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;           // padded to 56

endpackage : ccbu_pkg
`default_nettype wire

// ----- rtl/core/centre_crop_bilinear_upscale_x2.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// centre_crop_bilinear_upscale_x2
// Digital 2x zoom: crop the central half of a grey frame and emit one
// bilinear 2x2 output quad per window pixel that closes a 2x2 source block.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one 8-bit grey pixel per transfer in raster order; tuser
//   flags the first pixel of a frame and resets the column and row counters.
//   Master stream: one quad per transfer (position and four pixels), tlast
//   set on the last quad of the output frame. Pixels outside the window, and
//   those on the first window row or column, give no transfer.
//   APB port: frame_width at 0x0, frame_height at 0x4 (12 bits each). Write
//   only while the stream is idle; the new size applies to the next pixel.
// Timing:
//   Two register stages: the line store read and pixel capture, then the
//   output register. A quad passes through the capture stage, where it waits
//   while the output slot is full, and then through the output register.
//   One pixel per cycle is sustained while m_tready is high; the single line
//   store port pair (one read at capture, one write at commit) sets that figure.
// Reset:
//   Counters, neighbour registers and valid flags clear; sizes go to
//   1920x1080. The line store is not cleared: each frame writes a window
//   row before reading it back.
// Stalls:
//   While m_tready is low, the held quad stays put. Pixels that give no quad
//   keep flowing through the capture stage; the first pixel that gives a quad
//   waits there, and s_tready stays low until the held quad leaves.
// ----------------------------------------------------------------------------
module centre_crop_bilinear_upscale_x2
  import ccbu_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // pixel input
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [PIX_W-1:0]   s_tdata,   // [7:0] pixel
  input  wire logic               s_tuser,   // [0] frame_start
  // quad output
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [TDATA_W-1:0]      m_tdata,   // [10:0] quad_x, [21:11] quad_y,
                                             // [29:22] top_left, [37:30] top_right,
                                             // [45:38] bottom_left,
                                             // [53:46] bottom_right, [55:54] zero
  output logic                    m_tlast,   // frame_end
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // Derived widths
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int GW         = $clog2(MAX_DIM + 1);          // holds a size
  localparam int CLW        = (GW > CFG_W) ? GW : CFG_W;    // clamp arithmetic
  localparam int CXW        = $clog2(MAX_WIDTH);            // column counter
  localparam int CYW        = $clog2(MAX_HEIGHT);           // row counter
  localparam int LINE_DEPTH = MAX_WIDTH / 2 + 1;
  localparam int LAW        = $clog2(LINE_DEPTH);           // window column
  localparam int LAH        = $clog2(MAX_HEIGHT / 2 + 1);   // window row

  typedef struct packed {
    logic [GW-1:0] size;
    logic [GW-1:0] lo;    // size/4, first window index
    logic [GW-1:0] mid;   // size/2, last window offset
    logic [GW-1:0] hi;    // 3*size/4, last window index
  } geom_t;

  // Clamp to MIN_SIZE..maxv, round down to a multiple of four, split.
  function automatic geom_t size_geom(input logic [CFG_W-1:0] v,
                                      input logic [GW-1:0]    maxv);
    logic [CLW-1:0] c;
    geom_t          g;
    c = CLW'(v);
    if (c < CLW'(MIN_SIZE)) c = CLW'(MIN_SIZE);
    if (c > CLW'(maxv))     c = CLW'(maxv);
    g.size = GW'(c) & ~GW'(3);
    g.lo   = g.size >> 2;
    g.mid  = g.size >> 1;
    g.hi   = g.lo + g.mid;
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers; the crop geometry is worked out at write time
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  geom_t            geom_x;
  geom_t            geom_y;
  logic             cfg_write;
  reg_index_t       cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
      geom_x       <= size_geom(RESET_WIDTH, GW'(MAX_WIDTH));
      geom_y       <= size_geom(RESET_HEIGHT, GW'(MAX_HEIGHT));
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width <= pwdata[CFG_W-1:0];
          geom_x      <= size_geom(pwdata[CFG_W-1:0], GW'(MAX_WIDTH));
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= pwdata[CFG_W-1:0];
          geom_y       <= size_geom(pwdata[CFG_W-1:0], GW'(MAX_HEIGHT));
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_FRAME_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, frame_width};
      REG_FRAME_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, frame_height};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake control
  // ---------------------------------------------------------------------------
  logic in_xfer;
  logic s1_valid;
  logic s1_result;
  logic s1_commit;
  logic out_free;

  assign out_free  = !m_tvalid || m_tready;
  // capture stage leaves when it needs no output slot or one is free
  assign s1_commit = s1_valid && (!s1_result || out_free);
  assign s_tready  = !s1_valid || s1_commit;
  assign in_xfer   = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // Position counters and window decode for the incoming pixel
  // ---------------------------------------------------------------------------
  logic [CXW-1:0] column_count;
  logic [CYW-1:0] row_count;
  logic [CXW-1:0] col_cur;
  logic [CYW-1:0] row_cur;
  logic [CXW:0]   col_inc;
  logic [CYW:0]   row_inc;
  logic [CXW-1:0] column_count_next;
  logic [CYW-1:0] row_count_next;
  logic           in_window;
  logic [LAW-1:0] wx;
  logic [LAH-1:0] wy;

  always_comb begin
    // frame start restarts at the top left
    col_cur = s_tuser ? '0 : column_count;
    row_cur = s_tuser ? '0 : row_count;

    in_window = (GW'(col_cur) >= geom_x.lo) && (GW'(col_cur) <= geom_x.hi) &&
                (GW'(row_cur) >= geom_y.lo) && (GW'(row_cur) <= geom_y.hi);
    wx = LAW'(GW'(col_cur) - geom_x.lo);
    wy = LAH'(GW'(row_cur) - geom_y.lo);

    col_inc = {1'b0, col_cur} + 1'b1;
    row_inc = {1'b0, row_cur} + 1'b1;
    if (GW'(col_inc) >= geom_x.size) begin
      column_count_next = '0;
      row_count_next    = (GW'(row_inc) >= geom_y.size) ? '0 : row_inc[CYW-1:0];
    end else begin
      column_count_next = col_inc[CXW-1:0];
      row_count_next    = (GW'(row_cur) >= geom_y.size) ? '0 : row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_xfer) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Capture stage: pixel, window position and the line store read
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] window_line [LINE_DEPTH];
  logic [PIX_W-1:0] line_rd;
  logic [PIX_W-1:0] s1_pixel;
  logic [LAW-1:0]   s1_wx;
  logic [LAH-1:0]   s1_wy;
  logic             s1_in_window;
  logic             s1_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      line_rd      <= window_line[wx];
      s1_pixel     <= s_tdata;
      s1_wx        <= wx;
      s1_wy        <= wy;
      s1_in_window <= in_window;
      s1_result    <= in_window && (wx != '0) && (wy != '0);
      s1_end       <= (GW'(wx) == geom_x.mid) && (GW'(wy) == geom_y.mid);
    end
  end

  // store the current window pixel once its item leaves the capture stage
  always_ff @(posedge clk) begin
    if (s1_commit && s1_in_window) begin
      window_line[s1_wx] <= s1_pixel;
    end
  end

  // ---------------------------------------------------------------------------
  // Neighbour registers and quad arithmetic
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]  left_pixel;
  logic [PIX_W-1:0]  upper_left_pixel;
  logic [PIX_W:0]    sum_h;
  logic [PIX_W:0]    sum_v;
  logic [PIX_W+1:0]  sum_q;
  logic [QUAD_W-1:0] quad_x;
  logic [QUAD_W-1:0] quad_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else if (s1_commit && s1_in_window) begin
      left_pixel       <= s1_pixel;
      upper_left_pixel <= line_rd;
    end
  end

  always_comb begin
    sum_h  = {1'b0, upper_left_pixel} + {1'b0, line_rd};
    sum_v  = {1'b0, upper_left_pixel} + {1'b0, left_pixel};
    sum_q  = {1'b0, sum_h} + {2'b00, left_pixel} + {2'b00, s1_pixel};
    quad_x = QUAD_W'({s1_wx - 1'b1, 1'b0});
    quad_y = QUAD_W'({s1_wy - 1'b1, 1'b0});
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_commit && s1_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_commit && s1_result) begin
      m_tdata <= TDATA_W'({sum_q[PIX_W+1:2], sum_v[PIX_W:1], sum_h[PIX_W:1],
                           upper_left_pixel, quad_y, quad_x});
      m_tlast <= s1_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a quad only ever comes from a window pixel
  a_result_in_window: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_result |-> s1_in_window)
    else $error("quad from a pixel outside the window");

  // the last quad of a frame is always a real result
  a_end_has_result: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_end && s1_in_window |-> s1_result)
    else $error("frame end on a pixel with no quad");

  // line store read and write never collide on one entry
  a_no_line_collision: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_window && s1_commit && s1_in_window |-> wx != s1_wx)
    else $error("line store read and write hit the same entry");

  // a stalled capture stage keeps its item
  a_capture_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_commit |=> s1_valid && $stable(s1_wx) && $stable(s1_pixel))
    else $error("capture stage lost its item during a stall");

endmodule : centre_crop_bilinear_upscale_x2
`default_nettype wire
